/* rtl/lowest_free_id_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Lowest free ID allocator assertion macros
// Shared concurrent assertion forms used by the allocator's controller.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfa assertion failed");

// next-cycle implication, disabled while in reset
`define LFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfa assertion failed");

`endif

/* rtl/lfa_pkg.sv */
// ----------------------------------------------------------------------------
// Lowest free ID allocator package
// Sizes, result codes and the command/status bundles shared by the modules.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int ID_W       = 12;
    localparam int TDATA_W    = 16;
    localparam int CALC_W     = ADDR_W + BIT_W + ID_W;
    localparam int LAST_BITS  = SLOT_COUNT - WORD_BITS * (WORD_COUNT - 1);

    function automatic logic [WORD_BITS-1:0] last_word_mask();
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (i < LAST_BITS);
        end
        return m;
    endfunction

    localparam logic [WORD_BITS-1:0] LAST_MASK = last_word_mask();

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic    req_load;
        logic    rd_first;
        logic    rd_next;
        logic    rd_free;
        logic    wr_set;
        logic    wr_clear;
        logic    res_load;
        status_t res_code;
        logic    res_given;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic free_ok;
        logic found;
        logic last_word;
        logic bit_set;
    } sts_t;

endpackage

/* rtl/lowest_free_id_allocator.sv */
// ----------------------------------------------------------------------------
// Lowest free ID allocator
// Hands out the lowest free identifier base + 2*(slot+1) and takes them back.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser is the operation (0 allocate,
// 1 free) and s_tdata[11:0] the identifier to free. Each request produces
// exactly one result on the m_ stream: m_tdata[11:0] the identifier handed
// out (zero unless an allocate succeeded), m_tuser the status (0 done,
// 1 full, 2 free ignored). cfg_wr_en writes the base parity bit; write it
// only while no request is in flight.
// A free reads the used-bit word of its slot and clears the bit if it is set,
// else reports the free ignored; an identifier out of range or of the wrong
// parity is ignored without a read. An allocate reads the used-bit memory
// one 64-bit word per cycle from word 0 up to the first word with a free
// slot, or through all 1024 slots (16 words) when the store is full.
// One request is processed at a time; the next can be accepted in the same
// cycle that m_tvalid rises, even while the result waits there.
// Reset clears every used bit at once (one valid flag per memory word) and
// sets the base to zero; the block comes out of reset idle and ready.
// When the receiver stalls, the result is held and the block finishes at
// most one further request before it stops accepting.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [11:0] freed_id, [15:12] zero
    input  logic        s_tuser,     // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [11:0] given_id, [15:12] zero
    output logic [1:0]  m_tuser,     // [1:0] status
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import lfa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lfa_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* rtl/lfa_datapath.sv */
// ----------------------------------------------------------------------------
// Lowest free ID allocator datapath
// Used-bit memory, word scan, identifier arithmetic and result registers.
// ----------------------------------------------------------------------------
module lfa_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lfa_pkg::cmd_t          cmd,
    output lfa_pkg::sts_t          sts,
    input  logic [15:0]            s_tdata,     // [11:0] freed_id, rest zero
    input  logic                   s_tuser,     // [0] operation
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    output logic [15:0]            m_tdata,     // [11:0] given_id, rest zero
    output logic [1:0]             m_tuser      // [1:0] status
);
    import lfa_pkg::*;

    logic                  base_reg;
    op_t                   op_reg;
    logic [ID_W-1:0]       fid_reg;

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] row_valid_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [ADDR_W-1:0]     rd_addr_next;
    logic [ADDR_W-1:0]     scan_idx_reg;
    logic [ADDR_W-1:0]     scan_idx_next;
    logic                  rd_en;
    logic                  wr_en;

    logic [WORD_BITS-1:0]  eff_word;
    logic [WORD_BITS-1:0]  free_bits;
    logic [WORD_BITS-1:0]  wr_word;
    logic [BIT_W-1:0]      enc_bit;
    logic                  enc_found;

    logic [CALC_W-1:0]     fid_wide;
    logic [CALC_W-1:0]     first_id;
    logic [CALC_W-1:0]     fid_slot;
    logic [BIT_W-1:0]      free_bit;
    logic [CALC_W-1:0]     given_wide;

    logic [ID_W-1:0]       res_given_reg;
    status_t               res_status_reg;
    logic [15:0]           m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            op_reg  <= op_t'(s_tuser);
            fid_reg <= s_tdata[ID_W-1:0];
        end
    end

    // free request: slot of the given identifier
    always_comb begin
        fid_wide = CALC_W'(fid_reg);
        first_id = CALC_W'(base_reg) + CALC_W'(2);
        fid_slot = (fid_wide - first_id) >> 1;
        free_bit = fid_slot[BIT_W-1:0];
    end

    always_comb begin
        rd_en         = cmd.rd_first | cmd.rd_next | cmd.rd_free;
        wr_en         = cmd.wr_set | cmd.wr_clear;
        rd_addr_next  = rd_addr_reg;
        scan_idx_next = scan_idx_reg;
        priority if (cmd.rd_first) begin
            rd_addr_next  = '0;
            scan_idx_next = ADDR_W'(1);
        end else if (cmd.rd_next) begin
            rd_addr_next  = scan_idx_reg;
            scan_idx_next = scan_idx_reg + ADDR_W'(1);
        end else if (cmd.rd_free) begin
            rd_addr_next  = fid_slot[BIT_W +: ADDR_W];
        end else begin
            rd_addr_next  = rd_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg  <= '0;
            scan_idx_reg <= '0;
        end else begin
            rd_addr_reg  <= rd_addr_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr_next];
        end
        if (wr_en) begin
            mem[rd_addr_reg] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr_next];
            end
            if (wr_en) begin
                row_valid_reg[rd_addr_reg] <= 1'b1;
            end
        end
    end

    always_comb begin
        eff_word  = rd_valid_reg ? rd_data_reg : '0;
        free_bits = ~eff_word;
        if (rd_addr_reg == ADDR_W'(WORD_COUNT - 1)) begin
            free_bits = free_bits & LAST_MASK;
        end
        enc_bit   = '0;
        enc_found = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                enc_bit   = BIT_W'(i);
                enc_found = 1'b1;
            end
        end
    end

    always_comb begin
        wr_word = eff_word;
        if (cmd.wr_set) begin
            wr_word[enc_bit] = 1'b1;
        end else if (cmd.wr_clear) begin
            wr_word[free_bit] = 1'b0;
        end
    end

    always_comb begin
        given_wide = CALC_W'(base_reg)
                   + ((CALC_W'({rd_addr_reg, enc_bit}) + CALC_W'(1)) << 1);
    end

    always_comb begin
        sts.op        = op_reg;
        sts.free_ok   = (fid_wide >= first_id) && (fid_reg[0] == base_reg)
                        && (fid_slot < CALC_W'(SLOT_COUNT));
        sts.found     = enc_found;
        sts.last_word = (rd_addr_reg == ADDR_W'(WORD_COUNT - 1));
        sts.bit_set   = eff_word[free_bit];
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            res_given_reg  <= cmd.res_given ? given_wide[ID_W-1:0] : '0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= 16'(res_given_reg);
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

/* rtl/lfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Lowest free ID allocator controller
// Sequences request decode, word scan, used-bit update and result hand-off.
// ----------------------------------------------------------------------------
`include "lowest_free_id_allocator_macros.svh"

module lfa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output lfa_pkg::cmd_t cmd,
    input  lfa_pkg::sts_t sts
);
    import lfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_DECODE    = 5'b00010,
        S_SCAN      = 5'b00100,
        S_FREE_CHK  = 5'b01000,
        S_DONE      = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb begin
        cmd           = '0;
        cmd.res_code  = ST_DONE;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        s_tready      = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op == OP_ALLOC) begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_SCAN;
                end else if (sts.free_ok) begin
                    cmd.rd_free  = 1'b1;
                    state_next   = S_FREE_CHK;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_IGNORED;
                    state_next   = S_DONE;
                end
            end
            S_SCAN: begin
                if (sts.found) begin
                    cmd.wr_set    = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_given = 1'b1;
                    state_next    = S_DONE;
                end else if (sts.last_word) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_DONE;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_FREE_CHK: begin
                cmd.res_load = 1'b1;
                state_next   = S_DONE;
                if (sts.bit_set) begin
                    cmd.wr_clear = 1'b1;
                end else begin
                    cmd.res_code = ST_IGNORED;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `LFA_ASSERT_SAME(a_no_result_overwrite, aclk, aresetn, cmd.out_load, (!m_tvalid_reg || m_tready))
    `LFA_ASSERT_NEXT(a_one_request_at_a_time, aclk, aresetn, (s_tvalid && s_tready), !s_tready)
    `LFA_ASSERT_NEXT(a_scan_continues, aclk, aresetn, (state_reg == S_SCAN && !sts.found && !sts.last_word), (state_reg == S_SCAN))
    `LFA_ASSERT_SAME(a_write_needs_hit, aclk, aresetn, (cmd.wr_set || cmd.wr_clear), (sts.found || sts.bit_set))

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Lowest free ID allocator testbench
// Drives allocate and free requests through the request stream and checks
// each result against an in-bench bitmap model of the slot store or a typed
// table row's value. A short table of directed requests covers reuse of the
// lowest slot, every way a free can be ignored and base changes with slots
// held. Random traffic follows under varying back-pressure, then a fill of
// the whole store so that allocations run into the full condition, and more random traffic.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfa_pkg::*;

    typedef struct packed {
        logic [11:0] given_id;
        status_t     status;
    } id_outcome_t;

    typedef struct packed {
        logic        is_cfg;
        op_t         op;
        logic [11:0] id;
        logic        typed;
        logic [11:0] given_id;
        status_t     status;
    } dir_row_t;

    localparam int DIR_ROWS  = 25;
    localparam int HOLD_CYC  = 300;
    localparam int DRAIN_CYC = 25;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;

    id_outcome_t awaited_q [$];
    logic        slot_taken [SLOT_COUNT];
    logic        base_bit = 1'b0;
    int          taken_count = 0;
    int          fail_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_idle_pct = 0;
    int          hold_asked = 0;
    int          hold_done = 0;
    int          hold_left = 0;

    // is_cfg, op, id (cfg value in bit 0), typed, given_id, status
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{1'b1, OP_ALLOC, 12'd0,    1'b0, 12'd0, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd0,    1'b1, 12'd2, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd4095, 1'b1, 12'd4, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd0,    1'b1, 12'd6, ST_DONE},
        '{1'b0, OP_FREE,  12'd4,    1'b1, 12'd0, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd0,    1'b1, 12'd4, ST_DONE},
        '{1'b0, OP_FREE,  12'd5,    1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd0,    1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd2,    1'b1, 12'd0, ST_DONE},
        '{1'b0, OP_FREE,  12'd2,    1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd2050, 1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd4094, 1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd4095, 1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd2048, 1'b1, 12'd0, ST_IGNORED},
        '{1'b1, OP_ALLOC, 12'd1,    1'b0, 12'd0, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd0,    1'b1, 12'd3, ST_DONE},
        '{1'b0, OP_FREE,  12'd4,    1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd1,    1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd5,    1'b1, 12'd0, ST_DONE},
        '{1'b0, OP_FREE,  12'd2049, 1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_FREE,  12'd2051, 1'b1, 12'd0, ST_IGNORED},
        '{1'b0, OP_ALLOC, 12'd2730, 1'b0, 12'd0, ST_DONE},
        '{1'b1, OP_ALLOC, 12'd0,    1'b0, 12'd0, ST_DONE},
        '{1'b0, OP_FREE,  12'd6,    1'b0, 12'd0, ST_DONE},
        '{1'b0, OP_ALLOC, 12'd1365, 1'b0, 12'd0, ST_DONE}
    };

    lowest_free_id_allocator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_taken[i] = 1'b0;
        end
    end

    task automatic compute_outcome(input op_t op, input logic [11:0] fid,
                                   output id_outcome_t res);
        int s;
        int b;
        int f;
        int first;
        b = base_bit;
        f = fid;
        res.given_id = '0;
        res.status   = ST_DONE;
        if (op == OP_ALLOC) begin
            s = 0;
            while (s < SLOT_COUNT && slot_taken[s]) begin
                s++;
            end
            if (s == SLOT_COUNT) begin
                res.status = ST_FULL;
            end else begin
                slot_taken[s] = 1'b1;
                taken_count++;
                res.given_id = 12'(b + 2 * (s + 1));
            end
        end else begin
            first = b + 2;
            if (f < first || ((f - b) % 2) != 0) begin
                res.status = ST_IGNORED;
            end else begin
                s = (f - first) / 2;
                if (s >= SLOT_COUNT || !slot_taken[s]) begin
                    res.status = ST_IGNORED;
                end else begin
                    slot_taken[s] = 1'b0;
                    taken_count--;
                end
            end
        end
    endtask

    function automatic int pick_taken_slot();
        int start;
        int idx;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (start + k) % SLOT_COUNT;
            if (slot_taken[idx]) begin
                return idx;
            end
        end
        return -1;
    endfunction

    task automatic send_request(input op_t op, input logic [11:0] fid,
                                input logic typed, input id_outcome_t typed_res);
        id_outcome_t res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, fid};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        compute_outcome(op, fid, res);
        awaited_q.push_back(typed ? typed_res : res);
    endtask

    task automatic write_base(input logic v);
        s_tvalid <= 1'b0;
        while (awaited_q.size() != 0) begin
            @(posedge aclk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        base_bit = v;
    endtask

    task automatic random_request();
        int r;
        int s;
        logic [11:0] fid;
        op_t op;
        r   = $urandom_range(0, 99);
        s   = pick_taken_slot();
        fid = 12'($urandom_range(0, 4095));
        op  = OP_FREE;
        if (r < 50) begin
            op = OP_ALLOC;
        end else if (r < 78 && s >= 0) begin
            fid = 12'(base_bit + 2 * (s + 1));
        end else if (r < 86 && s >= 0) begin
            fid = 12'(base_bit + 2 * (s + 1) + 1);
        end else if (r < 93) begin
            fid = 12'(base_bit + 2 * SLOT_COUNT - 4 + $urandom_range(0, 8));
        end
        send_request(op, fid, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_done) begin
            m_tready  <= 1'b0;
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYC;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        id_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_q.size() == 0) begin
                $error("unexpected result: given_id %0d, status %0d", m_tdata[11:0], m_tuser);
                fail_count++;
            end else begin
                want = awaited_q.pop_front();
                if (m_tdata[11:0] !== want.given_id) begin
                    $error("given_id: expected %0d, actual %0d", want.given_id, m_tdata[11:0]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        id_outcome_t typed_res;
        sender_idle_pct   = 29;
        receiver_idle_pct = 54;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].is_cfg) begin
                write_base(dir_tab[k].id[0]);
            end else begin
                typed_res = '{dir_tab[k].given_id, dir_tab[k].status};
                send_request(dir_tab[k].op, dir_tab[k].id, dir_tab[k].typed, typed_res);
            end
        end

        write_base(1'b0);
        for (int k = 0; k < 30; k++) begin
            if (k == 10) begin
                hold_asked++;
            end
            random_request();
        end

        write_base(1'b1);
        sender_idle_pct   = 54;
        receiver_idle_pct = 29;
        repeat (30) random_request();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        while (taken_count < SLOT_COUNT) begin
            send_request(OP_ALLOC, 12'($urandom_range(0, 4095)), 1'b0, '0);
        end
        repeat (6) send_request(OP_ALLOC, 12'($urandom_range(0, 4095)), 1'b0, '0);
        repeat (15) random_request();
        write_base(1'b0);
        repeat (15) random_request();

        s_tvalid <= 1'b0;
        while (awaited_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lfa_pkg.sv
rtl/lfa_datapath.sv
rtl/lfa_ctrl.sv
rtl/lowest_free_id_allocator.sv
bench/tb_top.sv
